// File: rtl/mvt_pkg.sv
// Shared constants for the vector3_move_towards block.
// No dependencies; imported by every module of the block.
`default_nettype none
package mvt_pkg;
  localparam int COMP_WIDTH_DEF = 32;
  localparam int LANES          = 3;
endpackage
`default_nettype wire

// File: rtl/mvt_sqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on mvt_pkg; carries a sideband word alongside each operand.
`default_nettype none
module mvt_sqrt #(
  parameter int NB     = mvt_pkg::COMP_WIDTH_DEF + 2,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [2*NB-1:0]   in_sq,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [NB-1:0]          out_root,
  output logic [SIDE_W-1:0]      out_side
);
  import mvt_pkg::*;

  logic [NB-1:0]     v_r;
  logic [NB:0]       rem_r  [NB];
  logic [NB-1:0]     root_r [NB];
  logic [2*NB-1:0]   s_r    [NB];
  logic [SIDE_W-1:0] side_r [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic              p_v;
    logic [NB:0]       p_rem;
    logic [NB-1:0]     p_root;
    logic [2*NB-1:0]   p_s;
    logic [SIDE_W-1:0] p_side;
    logic [NB+1:0]     rem2;
    logic [NB+1:0]     trial;
    logic              ge;
    logic [NB+1:0]     diff;

    if (k == 0) begin : g_first
      assign p_v    = in_valid;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_s    = in_sq;
      assign p_side = in_side;
    end else begin : g_next
      assign p_v    = v_r[k-1];
      assign p_rem  = rem_r[k-1];
      assign p_root = root_r[k-1];
      assign p_s    = s_r[k-1];
      assign p_side = side_r[k-1];
    end

    always_comb begin
      rem2  = {p_rem[NB-1:0], p_s[2*NB-1 -: 2]};
      trial = {p_root, 2'b01};
      ge    = (rem2 >= trial);
      diff  = rem2 - trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[NB:0] : rem2[NB:0];
        root_r[k] <= {p_root[NB-2:0], ge};
        s_r[k]    <= {p_s[2*NB-3:0], 2'b00};
        side_r[k] <= p_side;
      end
    end
  end

  assign out_valid = v_r[NB-1];
  assign out_root  = root_r[NB-1];
  assign out_side  = side_r[NB-1];
endmodule
`default_nettype wire

// File: rtl/mvt_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one
// quotient bit per stage. Depends on mvt_pkg.
`default_nettype none
module mvt_div #(
  parameter int NB     = mvt_pkg::COMP_WIDTH_DEF + 2,
  parameter int QB     = mvt_pkg::COMP_WIDTH_DEF + 1,
  parameter int PW     = 2 * mvt_pkg::COMP_WIDTH_DEF + 1,
  parameter int SIDE_W = 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic [mvt_pkg::LANES-1:0][PW-1:0] in_num,
  input  wire logic [NB-1:0]                     in_den,
  input  wire logic [SIDE_W-1:0]                 in_side,
  output logic                                   out_valid,
  output logic [mvt_pkg::LANES-1:0][QB-1:0]      out_quo,
  output logic [SIDE_W-1:0]                      out_side
);
  import mvt_pkg::*;

  localparam int HW = PW - QB;

  logic [QB-1:0]             v_r;
  logic [NB-1:0]             den_r  [QB];
  logic [LANES-1:0][NB-1:0]  rem_r  [QB];
  logic [LANES-1:0][QB-1:0]  n_r    [QB];
  logic [LANES-1:0][QB-1:0]  q_r    [QB];
  logic [SIDE_W-1:0]         side_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic                     p_v;
    logic [NB-1:0]            p_den;
    logic [LANES-1:0][NB-1:0] p_rem;
    logic [LANES-1:0][QB-1:0] p_n;
    logic [LANES-1:0][QB-1:0] p_q;
    logic [SIDE_W-1:0]        p_side;
    logic [LANES-1:0][NB-1:0] rem_nxt;
    logic [LANES-1:0][QB-1:0] n_nxt;
    logic [LANES-1:0][QB-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign p_v    = in_valid;
      assign p_den  = in_den;
      assign p_side = in_side;
      for (genvar l = 0; l < LANES; l++) begin : g_ld
        assign p_rem[l] = {{(NB-HW){1'b0}}, in_num[l][PW-1:QB]};
        assign p_n[l]   = in_num[l][QB-1:0];
        assign p_q[l]   = '0;
      end
    end else begin : g_next
      assign p_v    = v_r[k-1];
      assign p_den  = den_r[k-1];
      assign p_rem  = rem_r[k-1];
      assign p_n    = n_r[k-1];
      assign p_q    = q_r[k-1];
      assign p_side = side_r[k-1];
    end

    always_comb begin
      logic [NB:0] rem2;
      logic [NB:0] diff;
      logic        ge;
      for (int l = 0; l < LANES; l++) begin
        rem2       = {p_rem[l], p_n[l][QB-1]};
        ge         = (rem2 >= {1'b0, p_den});
        diff       = rem2 - {1'b0, p_den};
        rem_nxt[l] = ge ? diff[NB-1:0] : rem2[NB-1:0];
        n_nxt[l]   = {p_n[l][QB-2:0], 1'b0};
        q_nxt[l]   = {p_q[l][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= p_den;
        rem_r[k]  <= rem_nxt;
        n_r[k]    <= n_nxt;
        q_r[k]    <= q_nxt;
        side_r[k] <= p_side;
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign out_quo   = q_r[QB-1];
  assign out_side  = side_r[QB-1];
endmodule
`default_nettype wire

// File: rtl/vector3_move_towards.sv
// Top level of vector3_move_towards: difference, squares, square root,
// scaling divide and saturation. Depends on mvt_pkg, mvt_sqrt, mvt_div.
//
// Usage: one stream word in, one word out per item. in_tdata holds, from
// the lowest bit up, cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z, max_step,
// each COMP_WIDTH bits, zero padded to whole bytes. out_tdata holds new_x,
// new_y, new_z; out_tuser holds snapped.
// A word passes the difference, magnitude, square and sum registers, the
// square root stages, the numerator register, the divider stages and the
// output register. One word per cycle except while the pipeline holds.
// Reset clears all stage valid bits; no word is in flight afterwards.
// When out_tready is low with a word waiting, the whole pipeline holds
// and in_tready drops; nothing is lost or repeated.
`default_nettype none
module vector3_move_towards #(
  parameter int COMP_WIDTH = mvt_pkg::COMP_WIDTH_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_tvalid,
  output logic                                          in_tready,
  // cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z, max_step
  input  wire logic [((7*COMP_WIDTH+7)/8)*8-1:0]        in_tdata,
  output logic                                          out_tvalid,
  input  wire logic                                     out_tready,
  // new_x, new_y, new_z
  output logic [((3*COMP_WIDTH+7)/8)*8-1:0]             out_tdata,
  // snapped
  output logic                                          out_tuser
);
  import mvt_pkg::*;

  localparam int W     = COMP_WIDTH;
  localparam int DW    = W + 1;
  localparam int NB    = W + 2;
  localparam int QB    = W + 1;
  localparam int PW    = 2 * W + 1;
  localparam int OB    = ((3*W+7)/8)*8;

  typedef struct packed {
    logic [LANES-1:0][W-1:0]  cur;
    logic [LANES-1:0][W-1:0]  tgt;
    logic [W-1:0]             step;
    logic [LANES-1:0][DW-1:0] mag;
    logic [LANES-1:0]         neg;
  } sq_side_t;

  typedef struct packed {
    logic [LANES-1:0][W-1:0] cur;
    logic [LANES-1:0][W-1:0] tgt;
    logic                    snap;
    logic [LANES-1:0]        neg;
  } dv_side_t;

  logic en;

  logic                     va_r, vb_r, vc_r, vd_r, ve_r, out_valid_r;
  logic [LANES-1:0][W-1:0]  cur_a_r, tgt_a_r;
  logic [W-1:0]             step_a_r;
  logic [LANES-1:0][DW-1:0] d_a_r;
  sq_side_t                 side_b_r, side_c_r;
  logic [LANES-1:0][2*DW-1:0] sq_c_r;
  logic [2*NB-1:0]          sum_d_r;
  sq_side_t                 side_d_r;
  logic                     sq_valid;
  logic [NB-1:0]            sq_root;
  sq_side_t                 sq_side;
  logic [LANES-1:0][PW-1:0] prod_e_r;
  logic [NB-1:0]            len_e_r;
  dv_side_t                 side_e_r;
  logic                     dv_valid;
  logic [LANES-1:0][QB-1:0] dv_quo;
  dv_side_t                 dv_side;
  logic [OB-1:0]            out_tdata_r;
  logic                     out_tuser_r;
  logic [LANES-1:0][W-1:0]  new_nxt;
  logic [W-1:0]             step_abs;
  logic                     snap_nxt;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      va_r <= in_tvalid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= sq_valid;
      out_valid_r <= dv_valid;
    end
  end

  // difference, magnitude, square, sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        cur_a_r[l] <= in_tdata[l*W +: W];
        tgt_a_r[l] <= in_tdata[(l+3)*W +: W];
        d_a_r[l]   <= {in_tdata[(l+3)*W+W-1], in_tdata[(l+3)*W +: W]}
                    - {in_tdata[l*W+W-1], in_tdata[l*W +: W]};
      end
      step_a_r <= in_tdata[6*W +: W];

      side_b_r.cur  <= cur_a_r;
      side_b_r.tgt  <= tgt_a_r;
      side_b_r.step <= step_a_r;
      for (int l = 0; l < LANES; l++) begin
        side_b_r.mag[l] <= d_a_r[l][DW-1] ? (~d_a_r[l] + 1'b1) : d_a_r[l];
        side_b_r.neg[l] <= d_a_r[l][DW-1];
      end

      side_c_r <= side_b_r;
      for (int l = 0; l < LANES; l++) begin
        sq_c_r[l] <= side_b_r.mag[l] * side_b_r.mag[l];
      end

      side_d_r <= side_c_r;
      sum_d_r  <= {2'b00, sq_c_r[0]} + {2'b00, sq_c_r[1]} + {2'b00, sq_c_r[2]};
    end
  end

  mvt_sqrt #(.NB(NB), .SIDE_W($bits(sq_side_t))) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vd_r),
    .in_sq     (sum_d_r),
    .in_side   (side_d_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // snap decision and numerators
  always_comb begin
    step_abs = sq_side.step[W-1] ? (~sq_side.step + 1'b1) : sq_side.step;
    snap_nxt = (sq_root == '0) ||
               (!sq_side.step[W-1] && (sq_root <= {2'b00, sq_side.step}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_e_r       <= sq_root;
      side_e_r.cur  <= sq_side.cur;
      side_e_r.tgt  <= sq_side.tgt;
      side_e_r.snap <= snap_nxt;
      for (int l = 0; l < LANES; l++) begin
        prod_e_r[l]     <= sq_side.mag[l] * step_abs;
        side_e_r.neg[l] <= sq_side.neg[l] ^ sq_side.step[W-1];
      end
    end
  end

  mvt_div #(.NB(NB), .QB(QB), .PW(PW), .SIDE_W($bits(dv_side_t))) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ve_r),
    .in_num    (prod_e_r),
    .in_den    (len_e_r),
    .in_side   (side_e_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // signed step, add and saturate, or snap to target
  always_comb begin
    logic [W+2:0] delta;
    logic [W+2:0] sum;
    for (int l = 0; l < LANES; l++) begin
      delta = dv_side.neg[l] ? (~{2'b00, dv_quo[l]} + 1'b1) : {2'b00, dv_quo[l]};
      sum   = {{3{dv_side.cur[l][W-1]}}, dv_side.cur[l]} + delta;
      if (dv_side.snap) begin
        new_nxt[l] = dv_side.tgt[l];
      end else if (sum[W+2:W-1] == '0 || sum[W+2:W-1] == '1) begin
        new_nxt[l] = sum[W-1:0];
      end else if (sum[W+2]) begin
        new_nxt[l] = {1'b1, {(W-1){1'b0}}};
      end else begin
        new_nxt[l] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {{(OB-3*W){1'b0}}, new_nxt};
      out_tuser_r <= dv_side.snap;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
endmodule
`default_nettype wire
